>>> sv/kcl_pkg.sv
// kcl_pkg: shared types and constants for the keypad code lock controller
// transaction structs, key codes, message codes and mode encoding
// no dependencies
`timescale 1ns / 1ps

package kcl_pkg;

  localparam int KCL_CODE_LENGTH = 4;

  localparam logic [7:0] KEY_NONE = 8'hFF;
  localparam logic [7:0] KEY_A    = 8'h41;
  localparam logic [7:0] KEY_B    = 8'h42;
  localparam logic [7:0] KEY_C    = 8'h43;
  localparam logic [7:0] KEY_D    = 8'h44;
  localparam logic [7:0] KEY_ZERO = 8'h30;

  localparam logic [3:0] FAIL_LIMIT_RST = 4'd5;
  localparam logic [3:0] HOLD_TICKS_RST = 4'd5;
  localparam logic [3:0] HOLD_MAX       = 4'd15;

  localparam logic [1:0] CFG_FAIL_LIMIT = 2'd0;
  localparam logic [1:0] CFG_HOLD_TICKS = 2'd1;

  localparam logic [3:0] MSG_NONE         = 4'd0;
  localparam logic [3:0] MSG_ENTER_CODE   = 4'd1;
  localparam logic [3:0] MSG_ALREADY_OPEN = 4'd2;
  localparam logic [3:0] MSG_ALREADY_SHUT = 4'd3;
  localparam logic [3:0] MSG_UNLOCKED     = 4'd4;
  localparam logic [3:0] MSG_LOCKED       = 4'd5;
  localparam logic [3:0] MSG_WRONG        = 4'd6;
  localparam logic [3:0] MSG_RESET_CHOICE = 4'd7;
  localparam logic [3:0] MSG_ENTER_OLD    = 4'd8;
  localparam logic [3:0] MSG_ENTER_NEW    = 4'd9;
  localparam logic [3:0] MSG_ZERO_REFUSED = 4'd10;
  localparam logic [3:0] MSG_CHANGED      = 4'd11;

  typedef enum logic [7:0] {
    MODE_IDLE         = 8'b0000_0001,
    MODE_ENTER_CODE   = 8'b0000_0010,
    MODE_CODE_CONFIRM = 8'b0000_0100,
    MODE_RESET_CHOICE = 8'b0000_1000,
    MODE_ENTER_OLD    = 8'b0001_0000,
    MODE_OLD_CONFIRM  = 8'b0010_0000,
    MODE_ENTER_NEW    = 8'b0100_0000,
    MODE_NEW_CONFIRM  = 8'b1000_0000
  } kcl_mode_t;

  typedef struct packed {
    logic       req_type;
    logic [7:0] key_code;
    logic       btn_held;
  } kcl_in_t;

  typedef struct packed {
    logic       lock_open;
    logic       buzzer_on;
    logic       alarm_pulse;
    logic [3:0] message;
    logic       echo_valid;
    logic [7:0] echo_key;
  } kcl_out_t;

endpackage

>>> sv/keypad_code_lock_controller.sv
// keypad_code_lock_controller: keypad code lock with code change and failure alarm
// depends on kcl_pkg for transaction structs, key and message codes
//
//   channel | ports                              | payload
//   input   | in_valid, in_ready, in_data        | kcl_in_t: req_type, key_code, btn_held
//   result  | out_valid, out_ready, out_data     | kcl_out_t: one result per input transaction
//   config  | cfg_valid, cfg_ready, cfg_index    | cfg_data: 4-bit register value
//
// one transaction per cycle sustained while out_ready stays high; input register, then result register
// all state updates for a transaction happen in the cycle it leaves the input register
// a stalled result holds the input register, which in turn drops in_ready
// cfg_ready is always high; indexes beyond the register list are ignored
// synchronous active-low reset: lock open, mode idle, stored code all '0'
`timescale 1ns / 1ps

module keypad_code_lock_controller
  import kcl_pkg::*;
#(
  parameter int CODE_LENGTH = KCL_CODE_LENGTH
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  kcl_in_t    in_data,
  output logic       out_valid,
  input  logic       out_ready,
  output kcl_out_t   out_data,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [3:0] cfg_data
);

  localparam int IDX_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;

  logic             s1_valid_r;
  kcl_in_t          s1_data_r;
  logic             s1_fire;
  logic             out_valid_r;
  kcl_out_t         out_data_r;

  logic [3:0]       fail_limit_r;
  logic [3:0]       hold_ticks_r;

  logic [7:0]       stored_code_r [CODE_LENGTH];
  logic [7:0]       stored_code_nxt [CODE_LENGTH];
  logic [7:0]       entry_buf_r [CODE_LENGTH];
  logic [7:0]       entry_buf_nxt [CODE_LENGTH];
  logic [7:0]       entry_buf_wr [CODE_LENGTH];
  logic [IDX_W-1:0] digit_idx_r;
  logic [IDX_W-1:0] digit_idx_nxt;
  logic             lock_r;
  logic             lock_nxt;
  kcl_mode_t        mode_r;
  kcl_mode_t        mode_nxt;
  logic             pending_r;
  logic             pending_nxt;
  logic [3:0]       fail_count_r;
  logic [3:0]       fail_count_nxt;
  logic [3:0]       hold_count_r;
  logic [3:0]       hold_count_nxt;

  logic             is_tick;
  logic             held;
  logic             is_key;
  logic [7:0]       key;
  logic             buf_full;
  logic             code_match;
  logic             code_zero;
  logic             take_digit;
  logic             fail_evt;
  logic [3:0]       hold_inc;
  logic [3:0]       fail_inc;
  kcl_out_t         res;

  assign s1_fire   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || s1_fire;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  always_comb begin
    is_tick  = s1_data_r.req_type;
    key      = s1_data_r.key_code;
    held     = s1_data_r.btn_held;
    is_key   = !is_tick && (key != KEY_NONE);
    buf_full = (digit_idx_r == IDX_W'(CODE_LENGTH - 1));
    for (int i = 0; i < CODE_LENGTH; i++) begin
      entry_buf_wr[i] = (digit_idx_r == IDX_W'(i)) ? key : entry_buf_r[i];
    end
    code_match = 1'b1;
    code_zero  = 1'b1;
    for (int i = 0; i < CODE_LENGTH; i++) begin
      if (entry_buf_wr[i] != stored_code_r[i]) begin
        code_match = 1'b0;
      end
      if (entry_buf_wr[i] != KEY_ZERO) begin
        code_zero = 1'b0;
      end
    end
    hold_inc = (hold_count_r != HOLD_MAX) ? hold_count_r + 4'd1 : hold_count_r;
    fail_inc = fail_count_r + 4'd1;

    mode_nxt       = mode_r;
    lock_nxt       = lock_r;
    pending_nxt    = pending_r;
    fail_count_nxt = fail_count_r;
    hold_count_nxt = hold_count_r;
    digit_idx_nxt  = digit_idx_r;
    stored_code_nxt = stored_code_r;
    take_digit     = 1'b0;
    fail_evt       = 1'b0;
    res            = '0;

    case (mode_r)
      MODE_IDLE: begin
        if (held) begin
          res.buzzer_on = 1'b1;
          if (is_tick) begin
            hold_count_nxt = hold_inc;
            if (hold_inc >= hold_ticks_r) begin
              hold_count_nxt = '0;
              res.buzzer_on  = 1'b0;
              res.message    = MSG_RESET_CHOICE;
              mode_nxt       = MODE_RESET_CHOICE;
            end
          end
        end else begin
          hold_count_nxt = '0;
          if (is_key && key == KEY_C) begin
            if (lock_r) begin
              res.message = MSG_ALREADY_OPEN;
            end else begin
              pending_nxt   = 1'b1;
              digit_idx_nxt = '0;
              res.message   = MSG_ENTER_CODE;
              mode_nxt      = MODE_ENTER_CODE;
            end
          end else if (is_key && key == KEY_D) begin
            if (!lock_r) begin
              res.message = MSG_ALREADY_SHUT;
            end else begin
              pending_nxt   = 1'b0;
              digit_idx_nxt = '0;
              res.message   = MSG_ENTER_CODE;
              mode_nxt      = MODE_ENTER_CODE;
            end
          end
        end
      end
      MODE_ENTER_CODE: begin
        take_digit = is_key;
        if (is_key && buf_full) begin
          if (code_match) begin
            mode_nxt = MODE_CODE_CONFIRM;
          end else begin
            fail_evt = 1'b1;
          end
        end
      end
      MODE_CODE_CONFIRM: begin
        if (is_key && key == KEY_A) begin
          fail_count_nxt = '0;
          lock_nxt       = pending_r;
          res.message    = pending_r ? MSG_UNLOCKED : MSG_LOCKED;
          mode_nxt       = MODE_IDLE;
        end
      end
      MODE_RESET_CHOICE: begin
        if (is_key && key == KEY_A) begin
          digit_idx_nxt = '0;
          res.message   = MSG_ENTER_OLD;
          mode_nxt      = MODE_ENTER_OLD;
        end else if (is_key && key == KEY_B) begin
          mode_nxt = MODE_IDLE;
        end
      end
      MODE_ENTER_OLD: begin
        take_digit = is_key;
        if (is_key && buf_full) begin
          if (code_match) begin
            mode_nxt = MODE_OLD_CONFIRM;
          end else begin
            fail_evt = 1'b1;
          end
        end
      end
      MODE_OLD_CONFIRM: begin
        if (is_key && key == KEY_A) begin
          fail_count_nxt = '0;
          digit_idx_nxt  = '0;
          res.message    = MSG_ENTER_NEW;
          mode_nxt       = MODE_ENTER_NEW;
        end
      end
      MODE_ENTER_NEW: begin
        take_digit = is_key;
        if (is_key && buf_full) begin
          if (code_zero) begin
            res.message = MSG_ZERO_REFUSED;
          end else begin
            mode_nxt = MODE_NEW_CONFIRM;
          end
        end
      end
      MODE_NEW_CONFIRM: begin
        if (is_key && key == KEY_A) begin
          stored_code_nxt = entry_buf_r;
          res.message     = MSG_CHANGED;
          mode_nxt        = MODE_IDLE;
        end
      end
      default: begin
        mode_nxt = MODE_IDLE;
      end
    endcase

    if (take_digit) begin
      entry_buf_nxt  = entry_buf_wr;
      digit_idx_nxt  = buf_full ? '0 : digit_idx_r + IDX_W'(1);
      res.echo_valid = 1'b1;
      res.echo_key   = key;
    end else begin
      entry_buf_nxt = entry_buf_r;
    end

    if (fail_evt) begin
      if (fail_count_r < fail_limit_r) begin
        fail_count_nxt  = fail_inc;
        res.alarm_pulse = (fail_inc == fail_limit_r);
      end
      res.message = MSG_WRONG;
      mode_nxt    = MODE_IDLE;
    end

    res.lock_open = lock_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      fail_limit_r <= FAIL_LIMIT_RST;
      hold_ticks_r <= HOLD_TICKS_RST;
      for (int i = 0; i < CODE_LENGTH; i++) begin
        stored_code_r[i] <= KEY_ZERO;
      end
      digit_idx_r  <= '0;
      lock_r       <= 1'b1;
      mode_r       <= MODE_IDLE;
      pending_r    <= 1'b0;
      fail_count_r <= '0;
      hold_count_r <= '0;
    end else begin
      if (in_ready) begin
        s1_valid_r <= in_valid;
      end
      if (s1_fire) begin
        out_valid_r   <= 1'b1;
        stored_code_r <= stored_code_nxt;
        digit_idx_r   <= digit_idx_nxt;
        lock_r        <= lock_nxt;
        mode_r        <= mode_nxt;
        pending_r     <= pending_nxt;
        fail_count_r  <= fail_count_nxt;
        hold_count_r  <= hold_count_nxt;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_FAIL_LIMIT: fail_limit_r <= cfg_data;
          CFG_HOLD_TICKS: hold_ticks_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_data_r <= in_data;
    end
    if (s1_fire) begin
      out_data_r  <= res;
      entry_buf_r <= entry_buf_nxt;
    end
  end

  // lock level changes only with an unlocked or locked message
  a_lock_msg: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && (lock_nxt != lock_r) |=>
      (out_data_r.message == MSG_UNLOCKED || out_data_r.message == MSG_LOCKED))
    else $error("lock changed without unlock or lock message");

  // alarm only comes with a wrong-code result
  a_alarm_wrong: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.alarm_pulse |-> out_data_r.message == MSG_WRONG)
    else $error("alarm pulse without wrong-code message");

  // failure count never passes the limit through a failure
  a_fail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    s1_fire && fail_evt && (fail_count_r < fail_limit_r) |=>
      fail_count_r <= fail_limit_r)
    else $error("failure count overran limit");

  // buzzer only sounds in idle with no message
  a_buzzer_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.buzzer_on |->
      (out_data_r.message == MSG_NONE && !out_data_r.echo_valid))
    else $error("buzzer on together with message or echo");

endmodule
